@@ hdl/lkv_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
// Used by lkv_cfg, lkv_store and lru_key_value_cache; depends on nothing.
package lkv_pkg;

  localparam int KEY_W               = 32;
  localparam int VALUE_W             = 32;
  localparam int CAP_W               = 5;
  localparam int MAX_ENTRIES_DEFAULT = 16;

  localparam logic [CAP_W-1:0]   CAPACITY_RESET = CAP_W'(16);
  localparam logic [VALUE_W-1:0] MISS_VALUE     = '1;
  localparam logic [VALUE_W-1:0] STORE_VALUE    = '0;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_STORE  = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lkv_req_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
  } lkv_rsp_t;

endpackage

@@ hdl/lkv_cfg.sv @@
// Capacity register with its write port and the saturated effective capacity.
// Depends on lkv_pkg.
module lkv_cfg #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_valid,
  output logic                               wr_ready,
  input  logic [lkv_pkg::CAP_W-1:0]          wr_data,
  output logic [$clog2(MAX_ENTRIES + 1)-1:0] eff_cap
);
  import lkv_pkg::*;

  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CMP_W-1:0] eff_ext;

  // Writes must arrive only while the block is idle; the block does not enforce this. The port is always ready.
  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (wr_valid && wr_ready) begin
      capacity <= wr_data;
    end
  end

  // A capacity of zero behaves as one; anything above the store size saturates.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    max_ext = CMP_W'(MAX_ENTRIES);
    if (cap_ext == '0) begin
      eff_ext = CMP_W'(1);
    end else if (cap_ext > max_ext) begin
      eff_ext = max_ext;
    end else begin
      eff_ext = cap_ext;
    end
    eff_cap = OCC_W'(eff_ext);
  end

endmodule

@@ hdl/lkv_store.sv @@
// Entry storage with parallel key compare, recency ranks and replacement.
// Depends on lkv_pkg; state changes at the edge on which a request is processed.
module lkv_store #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  lkv_pkg::lkv_req_t                  req,
  input  logic [$clog2(MAX_ENTRIES + 1)-1:0] eff_cap,
  output lkv_pkg::lkv_rsp_t                  rsp
);
  import lkv_pkg::*;

  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [KEY_W-1:0]       keys   [MAX_ENTRIES];
  logic [VALUE_W-1:0]     values [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [RANK_W-1:0]      rank   [MAX_ENTRIES];
  logic [OCC_W-1:0]       occ;

  logic [MAX_ENTRIES-1:0] valid_next;
  logic [RANK_W-1:0]      rank_next [MAX_ENTRIES];
  logic [OCC_W-1:0]       occ_next;

  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] victim;
  logic [MAX_ENTRIES-1:0] victim_one;
  logic [MAX_ENTRIES-1:0] free_one;
  logic [MAX_ENTRIES-1:0] ins;
  logic [MAX_ENTRIES-1:0] key_we;
  logic [MAX_ENTRIES-1:0] val_we;
  logic [VALUE_W-1:0]     hit_value;
  logic [RANK_W-1:0]      hit_rank;
  logic                   hit;
  logic                   is_store;
  logic                   use_victim;

  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = valid[i] && (keys[i] == req.key);
      // Ranks of valid entries are unique, so the oldest holds occupancy minus one.
      victim[i] = valid[i] && (OCC_W'(rank[i]) == (occ - OCC_W'(1)));
      hit_value = hit_value | (match[i] ? values[i] : '0);
      hit_rank  = hit_rank | (match[i] ? rank[i] : '0);
    end
    hit        = |match;
    is_store   = (req.kind == REQ_STORE);
    victim_one = victim & (~victim + MAX_ENTRIES'(1));
    free_one   = ~valid & (valid + MAX_ENTRIES'(1));
    use_victim = (occ >= eff_cap) && (|victim);
    ins        = use_victim ? victim_one : free_one;
  end

  always_comb begin
    valid_next = valid;
    occ_next   = occ;
    rank_next  = rank;
    key_we     = '0;
    val_we     = '0;
    if (fire) begin
      if (hit) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (match[i]) begin
            rank_next[i] = '0;
          end else if (valid[i] && (rank[i] < hit_rank)) begin
            rank_next[i] = rank[i] + RANK_W'(1);
          end
        end
        val_we = is_store ? match : '0;
      end else if (is_store && (|ins)) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (ins[i]) begin
            rank_next[i] = '0;
          end else if (valid[i]) begin
            rank_next[i] = rank[i] + RANK_W'(1);
          end
        end
        valid_next = valid | ins;
        key_we     = ins;
        val_we     = ins;
        if (!use_victim) begin
          occ_next = occ + OCC_W'(1);
        end
      end
    end
  end

  always_comb begin
    rsp.hit = hit;
    if (is_store) begin
      rsp.read_value = STORE_VALUE;
    end else if (hit) begin
      rsp.read_value = hit_value;
    end else begin
      rsp.read_value = MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      valid <= valid_next;
      occ   <= occ_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (key_we[i]) begin
        keys[i] <= req.key;
      end
      if (val_we[i]) begin
        values[i] <= req.value;
      end
    end
  end

endmodule

@@ hdl/lru_key_value_cache.sv @@
// Top level of the fully associative LRU key/value cache.
// Depends on lkv_pkg, lkv_cfg and lkv_store.
//
//   Channel   Direction  Handshake                         Payload
//   request   in         in_valid / in_stall               req_type, key, value
//   response  out        out_valid / out_stall             hit, read_value
//   capacity  in         capacity_valid / capacity_ready   capacity
//
// One request is taken every clock cycle when the response side is not stalled.
// A request is registered in the request stage on acceptance and its response is
// then registered in the output register once that register is free.
// The key compare, rank update and replacement all sit between those two
// registers; the entry state is updated on the edge that loads the output register.
// Synchronous reset clears the valid bits, ranks, occupancy and both stages,
// and sets the capacity to sixteen; no clearing pass is needed.
// While the output register is full and stalled, the request stage holds and
// in_stall is raised as soon as that stage is occupied.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic signed [lkv_pkg::KEY_W-1:0]    key,
  input  logic signed [lkv_pkg::VALUE_W-1:0]  value,
  // Response channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit,
  output logic signed [lkv_pkg::VALUE_W-1:0]  read_value,
  // Capacity register write channel.
  input  logic                                capacity_valid,
  output logic                                capacity_ready,
  input  logic [lkv_pkg::CAP_W-1:0]           capacity
);
  import lkv_pkg::*;

  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

  logic             s1_valid;
  lkv_req_t         s1_req;
  logic             accept_in;
  logic             out_busy;
  logic             advance;
  lkv_rsp_t         rsp;
  logic [OCC_W-1:0] eff_cap;

  // The output register is busy when it holds a response the sink refuses.
  assign out_busy  = out_valid && out_stall;
  // The request stage moves into the output register whenever that is free,
  // and the entry state is updated on the same edge.
  assign advance   = s1_valid && !out_busy;
  assign in_stall  = s1_valid && out_busy;
  assign accept_in = in_valid && !in_stall;

  lkv_cfg #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (capacity_valid),
    .wr_ready (capacity_ready),
    .wr_data  (capacity),
    .eff_cap  (eff_cap)
  );

  lkv_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .req     (s1_req),
    .eff_cap (eff_cap),
    .rsp     (rsp)
  );

  // Request stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_req.kind  <= req_kind_t'(req_type);
      s1_req.key   <= key;
      s1_req.value <= value;
    end
  end

  // Response stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_busy) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit        <= rsp.hit;
      read_value <= rsp.read_value;
    end
  end

  // The stage is never stalled while it is empty.
  a_stall_needs_request: assert property (
    @(posedge clk) disable iff (rst) in_stall |-> s1_valid
  ) else $error("request stage stalled while empty");

  // A request that leaves the first stage always lands in the output register.
  a_advance_fills_output: assert property (
    @(posedge clk) disable iff (rst) advance |=> out_valid
  ) else $error("processed request produced no response");

  // A held request stays put and keeps its contents.
  a_held_request_stable: assert property (
    @(posedge clk) disable iff (rst) in_stall |=> s1_valid && $stable(s1_req)
  ) else $error("held request changed while stalled");

  // A stalled response is not overwritten by a new one.
  a_no_overwrite: assert property (
    @(posedge clk) disable iff (rst) out_busy |-> !advance
  ) else $error("response register overwritten while stalled");

endmodule

@@ sim/lkv_lru_scoreboard.sv @@
// Scoreboard for the LRU key/value cache: watches the request, response and capacity
// channels, keeps its own copy of the cache state and checks every response in order.
// Depends on lkv_pkg.
module lkv_lru_scoreboard
  import lkv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      req_type,
  input  logic [KEY_W-1:0]          key,
  input  logic [VALUE_W-1:0]        value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      hit,
  input  logic [VALUE_W-1:0]        read_value,
  input  logic                      capacity_valid,
  input  logic                      capacity_ready,
  input  logic [CAP_W-1:0]          capacity,
  output int                        errors,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = MAX_ENTRIES_DEFAULT;

  logic [KEY_W-1:0]   slot_key  [SLOTS];
  logic [VALUE_W-1:0] slot_data [SLOTS];
  logic               slot_used [SLOTS];
  int unsigned        slot_age  [SLOTS];
  int unsigned        fill;
  logic [CAP_W-1:0]   cap_reg;
  lkv_rsp_t           due_responses [$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  // Zero behaves as one and anything above the slot count saturates.
  function automatic int unsigned cap_limit();
    if (cap_reg == '0) return 1;
    if (cap_reg > SLOTS) return SLOTS;
    return cap_reg;
  endfunction

  // Slot s becomes the most recent; entries that were more recent age by one.
  function automatic void promote(int s);
    int unsigned prior;
    prior = slot_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && i != s && slot_age[i] < prior) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic lkv_rsp_t lru_access(req_kind_t kind, logic [KEY_W-1:0] k,
                                          logic [VALUE_W-1:0] v);
    lkv_rsp_t    rsp;
    int          found;
    int          victim;
    int unsigned oldest;
    found = -1;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;

    if (kind == REQ_LOOKUP) begin
      if (found >= 0) begin
        promote(found);
        rsp.hit = 1'b1;
        rsp.read_value = slot_data[found];
      end else begin
        rsp.hit = 1'b0;
        rsp.read_value = MISS_VALUE;
      end
      return rsp;
    end

    rsp.read_value = STORE_VALUE;
    if (found >= 0) begin
      slot_data[found] = v;
      promote(found);
      rsp.hit = 1'b1;
      return rsp;
    end
    rsp.hit = 1'b0;

    // A new key at or above capacity first drops the least recent entry.
    if (fill >= cap_limit()) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && (victim < 0 || slot_age[i] > oldest)) begin
          victim = i;
          oldest = slot_age[i];
        end
      if (victim >= 0) begin
        slot_used[victim] = 1'b0;
        fill--;
      end
    end
    if (victim < 0)
      for (int i = 0; i < SLOTS; i++)
        if (victim < 0 && !slot_used[i]) victim = i;
    if (victim < 0) return rsp;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_key[victim] = k;
    slot_data[victim] = v;
    slot_used[victim] = 1'b1;
    slot_age[victim] = 0;
    fill++;
    return rsp;
  endfunction

  always @(posedge clk) begin : watch
    lkv_rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i] = 0;
      end
      fill = 0;
      cap_reg = CAPACITY_RESET;
      due_responses.delete();
    end else begin
      // A response leaves only after its request has been accepted, so check first.
      if (out_valid && !out_stall) begin
        if (due_responses.size() == 0) begin
          $display("%0t: response with none due, hit %0b read_value %h",
                   $time, hit, read_value);
          errors++;
        end else begin
          want = due_responses.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit expected %0b got %0b", $time, want.hit, hit);
            errors++;
          end
          if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %h got %h",
                     $time, want.read_value, read_value);
            errors++;
          end
        end
      end
      if (capacity_valid && capacity_ready) cap_reg = capacity;
      if (in_valid && !in_stall)
        due_responses.push_back(lru_access(req_kind_t'(req_type), key, value));
    end
    outstanding = due_responses.size();
  end

endmodule

@@ sim/tb_lru_key_value_cache.sv @@
// Testbench top for the LRU key/value cache: clock, reset, request and capacity stimulus.
// Checking is done by lkv_lru_scoreboard; depends on lkv_pkg and lru_key_value_cache.
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;
  import lkv_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 160;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                req_type = 1'b0;
  logic [KEY_W-1:0]    key = '0;
  logic [VALUE_W-1:0]  value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                hit;
  logic [VALUE_W-1:0]  read_value;
  logic                capacity_valid = 1'b0;
  logic                capacity_ready;
  logic [CAP_W-1:0]    capacity = '0;

  int errors;
  int outstanding;
  int cycles = 0;

  // Shared between the stimulus process and the response sink.
  bit hold_outputs = 1'b0;
  bit sender_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  // The keys of one phase are drawn mostly from a small pool, so that lookups hit,
  // stores overwrite and the pool slightly exceeds capacity to force evictions.
  logic [KEY_W-1:0] key_pool [24];
  int               pool_size;

  lru_key_value_cache uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .key            (key),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .read_value     (read_value),
    .capacity_valid (capacity_valid),
    .capacity_ready (capacity_ready),
    .capacity       (capacity)
  );

  lkv_lru_scoreboard scoreboard (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .key            (key),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .read_value     (read_value),
    .capacity_valid (capacity_valid),
    .capacity_ready (capacity_ready),
    .capacity       (capacity),
    .errors         (errors),
    .outstanding    (outstanding)
  );

  always #5 clk = ~clk;

  // Watchdog: a run that reaches CYCLE_LIMIT is reported as a mismatch.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle stretches: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Response sink. It stalls at random, unless told to stay quiet, and on request it
  // holds off for a long counted stretch so that the cache fills and stalls its input.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_outputs) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_outputs = 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!sink_quiet && $urandom_range(0, 2) == 0) stall_left = gap_len();
      end
    end
  end

  // Offers one request, waits until it is taken and then idles for a random gap.
  // The valid line is left high when there is no gap, so back-to-back requests flow.
  task automatic offer(input req_kind_t kind, input logic [KEY_W-1:0] k,
                       input logic [VALUE_W-1:0] v);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= kind;
    key <= k;
    value <= v;
    do @(posedge clk); while (in_stall);
    gap = sender_quiet ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // The capacity is only changed once the cache is idle: the sender stops and
  // every response already due has to come back first.
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    capacity_valid <= 1'b1;
    capacity <= c;
    do @(posedge clk); while (!capacity_ready);
    @(negedge clk);
    capacity_valid <= 1'b0;
  endtask

  // One random phase at a given capacity. Most requests use keys from the pool;
  // a few use fresh random keys, which nearly always miss.
  task automatic run_phase(input logic [CAP_W-1:0] c, input bit with_hold);
    int               held;
    logic [KEY_W-1:0] k;
    set_capacity(c);
    held = (c == 0) ? 1 : ((c > MAX_ENTRIES_DEFAULT) ? MAX_ENTRIES_DEFAULT : int'(c));
    pool_size = held + $urandom_range(1, 6);
    for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
    if ($urandom_range(0, 1) == 1) key_pool[0] = 32'h8000_0000;
    if ($urandom_range(0, 1) == 1) key_pool[1] = 32'h7FFF_FFFF;
    sender_quiet = ($urandom_range(0, 3) == 0);
    sink_quiet = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (with_hold && n == PHASE_ITEMS / 3) hold_outputs = 1'b1;
      if ($urandom_range(0, 99) < 8) k = $urandom;
      else k = key_pool[$urandom_range(0, pool_size - 1)];
      offer(req_kind_t'($urandom_range(0, 1)), k, $urandom);
    end
    sender_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part at full capacity: a lookup in the empty cache, stores and
    // lookups at the key and value extremes, and an overwrite of a present key.
    set_capacity(CAP_W'(16));
    offer(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    offer(REQ_STORE,  32'h8000_0000, 32'h7FFF_FFFF);
    offer(REQ_STORE,  32'h7FFF_FFFF, 32'h8000_0000);
    offer(REQ_STORE,  32'h0000_0000, 32'hFFFF_FFFF);
    offer(REQ_STORE,  32'hFFFF_FFFF, 32'h0000_0000);
    offer(REQ_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
    offer(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    offer(REQ_STORE,  32'h7FFF_FFFF, 32'h0000_0001);
    offer(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    offer(REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000);

    // Capacity lowered below the four entries held: hits evict nothing, and each
    // new key evicts exactly one entry, the least recent one.
    set_capacity(CAP_W'(2));
    offer(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    offer(REQ_STORE,  32'h0000_0005, 32'h0000_0005);
    offer(REQ_STORE,  32'h0000_0006, 32'h0000_0006);
    offer(REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    offer(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    offer(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

    // A capacity of zero behaves as one entry.
    set_capacity(CAP_W'(0));
    offer(REQ_STORE,  32'hA5A5_A5A5, 32'h5A5A_5A5A);
    offer(REQ_STORE,  32'h5A5A_5A5A, 32'hA5A5_A5A5);
    offer(REQ_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000);
    offer(REQ_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000);

    // Capacities above sixteen saturate at the slot count.
    set_capacity(CAP_W'(31));
    offer(REQ_STORE,  32'h0000_0007, 32'h0000_0007);
    offer(REQ_LOOKUP, 32'h0000_0006, 32'h0000_0000);

    // Random phases through small, large and saturating capacities, with some
    // phases lowering the capacity below the occupancy left by the one before.
    run_phase(CAP_W'(1),  1'b0);
    run_phase(CAP_W'(0),  1'b0);
    run_phase(CAP_W'(5),  1'b0);
    run_phase(CAP_W'(16), 1'b1);
    run_phase(CAP_W'(31), 1'b0);
    run_phase(CAP_W'(3),  1'b0);
    run_phase(CAP_W'(20), 1'b0);
    run_phase(CAP_W'(8),  1'b1);
    run_phase(CAP_W'(2),  1'b0);
    run_phase(CAP_W'(12), 1'b0);
    run_phase(CAP_W'(17), 1'b0);
    run_phase(CAP_W'(16), 1'b0);

    // Let every due response drain, then wait for any stray response.
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
